FILE: hdl/csfe_pkg.sv
// Package for the clock set field editor.
// Types, field and key codes, bounds and BCD conversion helpers.
// No dependencies.
`default_nettype none

package csfe_pkg;

  localparam int NUM_FIELDS = 7;

  typedef logic [7:0] byte_t;
  typedef logic [2:0] field_t;
  typedef logic [NUM_FIELDS-1:0][7:0] field_vec_t;

  // Field order of the store and of the cursor
  localparam field_t FLD_DATE    = 3'd0;
  localparam field_t FLD_MONTH   = 3'd1;
  localparam field_t FLD_YEAR    = 3'd2;
  localparam field_t FLD_WEEKDAY = 3'd3;
  localparam field_t FLD_HOUR    = 3'd4;
  localparam field_t FLD_MINUTE  = 3'd5;
  localparam field_t FLD_SECOND  = 3'd6;
  localparam field_t FLD_NONE    = 3'd7;

  // Item kinds
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_KEY  = 1'b1;

  typedef enum logic [2:0] {
    KEY_NONE = 3'd0,
    KEY_DOWN = 3'd1,
    KEY_UP   = 3'd2,
    KEY_NEXT = 3'd3,
    KEY_EXIT = 3'd4
  } key_t;

  // Write command from the update logic to the store
  typedef struct packed {
    logic       load;
    logic       one;
    field_t     addr;
    byte_t      data;
    field_vec_t vals;
  } wr_cmd_t;

  function automatic byte_t lo_bound(input field_t f);
    byte_t b;
    case (f)
      FLD_DATE, FLD_MONTH, FLD_WEEKDAY: b = 8'd1;
      default:                          b = 8'd0;
    endcase
    return b;
  endfunction

  function automatic byte_t hi_bound(input field_t f);
    byte_t b;
    case (f)
      FLD_DATE:    b = 8'd31;
      FLD_MONTH:   b = 8'd12;
      FLD_YEAR:    b = 8'd99;
      FLD_WEEKDAY: b = 8'd7;
      FLD_HOUR:    b = 8'd23;
      default:     b = 8'd59;
    endcase
    return b;
  endfunction

  // High nibble times ten plus low nibble; at most 165, fits 8 bits
  function automatic byte_t bcd_to_bin(input byte_t v);
    byte_t h8;
    byte_t h2;
    h8 = {1'b0, v[7:4], 3'b000};
    h2 = {3'b000, v[7:4], 1'b0};
    return h8 + h2 + {4'b0000, v[3:0]};
  endfunction

  // Quotient by ten via reciprocal 205/2048, exact for 8-bit values
  function automatic byte_t bin_to_bcd(input byte_t v);
    logic [15:0] p;
    logic [4:0]  q;
    byte_t       q10;
    byte_t       r;
    p   = {8'b0, v} * 16'd205;
    q   = p[15:11];
    q10 = {q[4:0], 3'b000} + {2'b00, q[4:0], 1'b0};
    r   = v - q10;
    return {q[3:0], r[3:0]};
  endfunction

endpackage

`default_nettype wire

FILE: hdl/csfe_store.sv
// Field value store: seven entries with a registered read port.
// Uses csfe_pkg; a load writes every entry, an edit writes one.
`default_nettype none

module csfe_store
  import csfe_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       rd_en,
  input  wire field_t     rd_addr,
  output      byte_t      rd_data,
  input  wire wr_cmd_t    wr,
  output      field_vec_t taps
);

  byte_t mem [NUM_FIELDS];
  byte_t rd_fwd;

  // Write side
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_FIELDS; i++) mem[i] <= '0;
    end else if (wr.load) begin
      for (int i = 0; i < NUM_FIELDS; i++) mem[i] <= wr.vals[i];
    end else if (wr.one && wr.addr != FLD_NONE) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Read with forwarding of a write in the same cycle
  always_comb begin
    if (rd_addr == FLD_NONE) begin
      rd_fwd = '0;
    end else if (wr.load) begin
      rd_fwd = wr.vals[rd_addr];
    end else if (wr.one && wr.addr == rd_addr) begin
      rd_fwd = wr.data;
    end else begin
      rd_fwd = mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= rd_fwd;
    end
  end

  // Fixed taps for the result
  always_comb begin
    for (int i = 0; i < NUM_FIELDS; i++) taps[i] = mem[i];
  end

endmodule

`default_nettype wire

FILE: hdl/csfe_step.sv
// Update logic: turns one staged item into a store write and result fields.
// Uses csfe_pkg; reads the registered store port and the store taps.
`default_nettype none

module csfe_step
  import csfe_pkg::*;
(
  input  wire logic       en,
  input  wire logic       op,
  input  wire logic [2:0] key,
  input  wire field_t     cur,
  input  wire field_vec_t raw,
  input  wire byte_t      rd_data,
  input  wire field_vec_t taps,
  output      wr_cmd_t    wr,
  output      field_vec_t res,
  output      logic       commit
);

  byte_t lo;
  byte_t hi;
  byte_t post;

  assign lo = lo_bound(cur);
  assign hi = hi_bound(cur);

  // Write command
  always_comb begin
    wr      = '0;
    wr.addr = cur;
    commit  = 1'b0;
    for (int i = 0; i < NUM_FIELDS; i++) begin
      wr.vals[i] = (field_t'(i) == FLD_WEEKDAY) ? raw[i] : bcd_to_bin(raw[i]);
    end
    if (op == OP_LOAD) begin
      wr.load = en;
    end else begin
      case (key_t'(key))
        KEY_DOWN: begin
          wr.one  = en && (cur != FLD_NONE);
          wr.data = (rd_data == lo) ? hi : rd_data - 8'd1;
        end
        KEY_UP: begin
          wr.one  = en && (cur != FLD_NONE);
          wr.data = (rd_data == hi) ? lo : rd_data + 8'd1;
        end
        KEY_EXIT: commit = 1'b1;
        default:  ;
      endcase
    end
  end

  // Result fields from the values after this write
  always_comb begin
    for (int i = 0; i < NUM_FIELDS; i++) begin
      if (wr.load) begin
        post = wr.vals[i];
      end else if (wr.one && wr.addr == field_t'(i)) begin
        post = wr.data;
      end else begin
        post = taps[i];
      end
      res[i] = (field_t'(i) == FLD_WEEKDAY) ? post : bin_to_bcd(post);
    end
  end

endmodule

`default_nettype wire

FILE: hdl/clock_set_field_editor.sv
// Clock set field editor: an accepted item passes the stage 1 register and the
// output register to m_tvalid. One item per cycle while m_tready does not stall;
// the store forwards writes to reads, so no item waits on the one before it.
// s_tready follows m_tready combinationally only while both stages hold an item.
// Synchronous reset clears cursor, all field values and the valid flags.
`default_nettype none

module clock_set_field_editor
  import csfe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  // key[2:0], seconds[10:3], minutes[18:11], hours[26:19], weekday[34:27],
  // date[42:35], month[50:43], year[58:51], zero pad
  input  wire logic [63:0] s_tdata,
  // opcode[0]
  input  wire logic        s_tuser,
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  // seconds[7:0], minutes[15:8], hours[23:16], weekday[31:24], date[39:32],
  // month[47:40], year[55:48], selected_field[58:56], zero pad
  output      logic [63:0] m_tdata,
  // commit[0]
  output      logic        m_tuser
);

  logic       accept;
  logic       s1_adv;
  field_t     cursor;
  field_t     cursor_next;

  logic       s1_valid;
  logic       s1_op;
  logic [2:0] s1_key;
  field_t     s1_cur;
  field_vec_t s1_raw;

  byte_t      rd_data;
  field_vec_t taps;
  wr_cmd_t    wr;
  field_vec_t res;
  logic       res_commit;

  field_vec_t out_vals;
  field_t     out_cur;
  logic       out_commit;

  // Handshake
  assign s1_adv   = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || s1_adv;
  assign accept   = s_tvalid && s_tready;

  // Cursor update at accept
  always_comb begin
    cursor_next = cursor;
    if (s_tuser == OP_LOAD) begin
      cursor_next = FLD_DATE;
    end else if (s_tdata[2:0] == KEY_NEXT) begin
      cursor_next = (cursor >= FLD_SECOND) ? FLD_DATE : cursor + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= FLD_DATE;
    end else if (accept) begin
      cursor <= cursor_next;
    end
  end

  // Stage 1: staged item while the store read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op               <= s_tuser;
      s1_key              <= s_tdata[2:0];
      s1_cur              <= cursor_next;
      s1_raw[FLD_SECOND]  <= s_tdata[10:3];
      s1_raw[FLD_MINUTE]  <= s_tdata[18:11];
      s1_raw[FLD_HOUR]    <= s_tdata[26:19];
      s1_raw[FLD_WEEKDAY] <= s_tdata[34:27];
      s1_raw[FLD_DATE]    <= s_tdata[42:35];
      s1_raw[FLD_MONTH]   <= s_tdata[50:43];
      s1_raw[FLD_YEAR]    <= s_tdata[58:51];
    end
  end

  csfe_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (cursor),
    .rd_data (rd_data),
    .wr      (wr),
    .taps    (taps)
  );

  csfe_step u_step (
    .en      (s1_valid && s1_adv),
    .op      (s1_op),
    .key     (s1_key),
    .cur     (s1_cur),
    .raw     (s1_raw),
    .rd_data (rd_data),
    .taps    (taps),
    .wr      (wr),
    .res     (res),
    .commit  (res_commit)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv) begin
      out_vals   <= res;
      out_cur    <= s1_cur;
      out_commit <= res_commit;
    end
  end

  assign m_tdata = {5'b0, out_cur, out_vals[FLD_YEAR], out_vals[FLD_MONTH],
                    out_vals[FLD_DATE], out_vals[FLD_WEEKDAY], out_vals[FLD_HOUR],
                    out_vals[FLD_MINUTE], out_vals[FLD_SECOND]};
  assign m_tuser = out_commit;

  // Checks
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    cursor != FLD_NONE)
    else $error("cursor reached an unused code");

  a_load_home: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser == OP_LOAD) |=> (cursor == FLD_DATE && s1_cur == FLD_DATE))
    else $error("load did not home the cursor");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready && s1_valid) |-> !s_tready)
    else $error("input taken while pipeline is full");

  a_write_gated: assert property (@(posedge clk) disable iff (rst)
    (wr.load || wr.one) |-> (s1_valid && s1_adv))
    else $error("store written without an advancing item");

  a_commit_exit: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_adv && res_commit) |=> (m_tvalid && m_tuser))
    else $error("commit lost on the way to the output");

endmodule

`default_nettype wire

FILE: dv/csfe_checker.sv
// Checker for the clock set field editor: watches both streams, predicts
// every result from the accepted items and compares field by field.
// Depends on csfe_pkg for field, key and item codes.
`default_nettype none

module csfe_checker
  import csfe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [63:0] s_tdata,
  input  wire logic        s_tuser,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [63:0] m_tdata,
  input  wire logic        m_tuser,
  output int               mismatches,
  output int               open_results,
  output int               results_seen
);

  // Expected view of one result
  typedef struct packed {
    byte_t  seconds;
    byte_t  minutes;
    byte_t  hours;
    byte_t  weekday;
    byte_t  date;
    byte_t  month;
    byte_t  year;
    field_t cursor;
    logic   commit;
  } clock_view_t;

  // Per-field limits, indexed by field code
  localparam logic [NUM_FIELDS-1:0][7:0] FLOOR =
    {8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 8'd1, 8'd1};
  localparam logic [NUM_FIELDS-1:0][7:0] CEIL =
    {8'd59, 8'd59, 8'd23, 8'd7, 8'd99, 8'd12, 8'd31};

  byte_t       edit_vals [NUM_FIELDS];
  field_t      edit_cursor;
  clock_view_t pending_views [$];
  int          n_err     = 0;
  int          n_open    = 0;
  int          n_checked = 0;

  assign mismatches   = n_err;
  assign open_results = n_open;
  assign results_seen = n_checked;

  function automatic byte_t digits_to_bin(input byte_t v);
    return byte_t'(v[7:4] * 10 + v[3:0]);
  endfunction

  function automatic byte_t bin_to_digits(input byte_t v);
    int t;
    t = ((v / 10) << 4) + (v % 10);
    return t[7:0];
  endfunction

  task automatic log_failure(input string msg);
    n_err++;
    $display("csfe_checker: %s", msg);
  endtask

  task automatic check_value(input string what, input int got, input int want);
    if (got != want)
      log_failure($sformatf("result %0d %s: got %0h, want %0h", n_checked, what, got, want));
  endtask

  // Apply one accepted item to the edit state and return the view it produces
  task automatic edit_step(input logic op, input logic [63:0] d, output clock_view_t view);
    byte_t  v;
    logic   commit;
    commit = 1'b0;
    if (op == OP_LOAD) begin
      edit_vals[FLD_SECOND]  = digits_to_bin(d[10:3]);
      edit_vals[FLD_MINUTE]  = digits_to_bin(d[18:11]);
      edit_vals[FLD_HOUR]    = digits_to_bin(d[26:19]);
      edit_vals[FLD_WEEKDAY] = d[34:27];
      edit_vals[FLD_DATE]    = digits_to_bin(d[42:35]);
      edit_vals[FLD_MONTH]   = digits_to_bin(d[50:43]);
      edit_vals[FLD_YEAR]    = digits_to_bin(d[58:51]);
      edit_cursor = FLD_DATE;
    end else begin
      case (key_t'(d[2:0]))
        KEY_NEXT: begin
          edit_cursor = (edit_cursor >= FLD_SECOND) ? FLD_DATE : edit_cursor + 3'd1;
        end
        KEY_DOWN, KEY_UP: begin
          // a cursor of 7 is never reached, but would leave everything alone
          if (edit_cursor != FLD_NONE) begin
            v = edit_vals[edit_cursor];
            if (d[2:0] == KEY_DOWN)
              v = (v == FLOOR[edit_cursor]) ? CEIL[edit_cursor] : byte_t'(v - 8'd1);
            else
              v = (v == CEIL[edit_cursor]) ? FLOOR[edit_cursor] : byte_t'(v + 8'd1);
            edit_vals[edit_cursor] = v;
          end
        end
        KEY_EXIT: commit = 1'b1;
        default: ;
      endcase
    end
    view.seconds = bin_to_digits(edit_vals[FLD_SECOND]);
    view.minutes = bin_to_digits(edit_vals[FLD_MINUTE]);
    view.hours   = bin_to_digits(edit_vals[FLD_HOUR]);
    view.weekday = edit_vals[FLD_WEEKDAY];
    view.date    = bin_to_digits(edit_vals[FLD_DATE]);
    view.month   = bin_to_digits(edit_vals[FLD_MONTH]);
    view.year    = bin_to_digits(edit_vals[FLD_YEAR]);
    view.cursor  = edit_cursor;
    view.commit  = commit;
  endtask

  // Compare results first, then predict from the item accepted at this edge
  always @(posedge clk) begin
    clock_view_t want;
    clock_view_t next_view;
    if (rst) begin
      pending_views.delete();
      foreach (edit_vals[i]) edit_vals[i] = 8'd0;
      edit_cursor = FLD_DATE;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_views.size() == 0) begin
          log_failure($sformatf("result with nothing pending: data %h", m_tdata));
        end else begin
          want = pending_views.pop_front();
          check_value("seconds", m_tdata[7:0], want.seconds);
          check_value("minutes", m_tdata[15:8], want.minutes);
          check_value("hours", m_tdata[23:16], want.hours);
          check_value("weekday", m_tdata[31:24], want.weekday);
          check_value("date", m_tdata[39:32], want.date);
          check_value("month", m_tdata[47:40], want.month);
          check_value("year", m_tdata[55:48], want.year);
          check_value("selected_field", m_tdata[58:56], want.cursor);
          check_value("pad", m_tdata[63:59], 0);
          check_value("commit", m_tuser, want.commit);
        end
        n_checked++;
      end
      if (s_tvalid && s_tready) begin
        edit_step(s_tuser, s_tdata, next_view);
        pending_views.push_back(next_view);
      end
    end
    n_open <= pending_views.size();
  end

endmodule

`default_nettype wire

FILE: dv/tb_clock_set_field_editor.sv
// Testbench top for the clock set field editor: drives load and key items
// with random idling on both sides and gives the verdict.
// Depends on csfe_pkg, clock_set_field_editor and csfe_checker.
`default_nettype none

module tb_clock_set_field_editor
  import csfe_pkg::*;
();

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;
  logic        m_tuser;

  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  logic rx_hold     = 1'b0;
  int   n_bad;
  int   n_open;
  int   n_results;
  int   n_loads = 0;
  int   n_keys  = 0;

  clock_set_field_editor uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  csfe_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .mismatches   (n_bad),
    .open_results (n_open),
    .results_seen (n_results)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit
  initial begin
    #4000000;
    $display("tb_clock_set_field_editor: done, errors");
    $finish;
  end

  // Receiver side: random back-pressure, or held off during a stall stretch
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold) m_tready <= 1'b0;
      else m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Offer one item, with random gaps carrying junk, until it is taken
  task automatic send_item(input logic op, input logic [63:0] payload);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tuser  <= 1'($urandom);
      s_tdata  <= {$urandom, $urandom};
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= payload;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_load(input byte_t sec, input byte_t mins, input byte_t hrs,
                           input byte_t wday, input byte_t mday, input byte_t mon,
                           input byte_t yr, input logic [2:0] k);
    n_loads++;
    send_item(OP_LOAD, {5'b0, yr, mon, mday, wday, hrs, mins, sec, k});
  endtask

  // Register bytes are don't-care on a key item, so fill them with noise
  task automatic send_key(input logic [2:0] k);
    n_keys++;
    send_item(OP_KEY, {5'b0, $urandom, 24'($urandom), k});
  endtask

  // BCD value within limits, leaning toward the limits themselves
  function automatic byte_t rand_bcd(input int lo, input int hi);
    int v;
    case ($urandom_range(7))
      0:       v = lo;
      1:       v = hi;
      default: v = $urandom_range(hi, lo);
    endcase
    return {4'(v / 10), 4'(v % 10)};
  endfunction

  task automatic random_items(input int count);
    int         sent;
    int         pick;
    int         burst;
    logic [2:0] k;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        if ($urandom_range(3) != 0)
          send_load(rand_bcd(0, 59), rand_bcd(0, 59), rand_bcd(0, 23),
                    byte_t'($urandom_range(7, 1)), rand_bcd(1, 31), rand_bcd(1, 12),
                    rand_bcd(0, 99), 3'($urandom));
        else
          send_load(byte_t'($urandom), byte_t'($urandom), byte_t'($urandom),
                    byte_t'($urandom), byte_t'($urandom), byte_t'($urandom),
                    byte_t'($urandom), 3'($urandom));
        sent++;
      end else begin
        pick = $urandom_range(99);
        if (pick < 30)      k = KEY_DOWN;
        else if (pick < 60) k = KEY_UP;
        else if (pick < 78) k = KEY_NEXT;
        else if (pick < 88) k = KEY_EXIT;
        else if (pick < 94) k = KEY_NONE;
        else                k = 3'($urandom_range(7, 5));
        // runs of up or down walk values across their wrap points
        burst = (k == KEY_DOWN || k == KEY_UP) ? $urandom_range(6, 1) : 1;
        repeat (burst) begin
          send_key(k);
          sent++;
        end
      end
    end
  endtask

  // Stop offering and wait for every pending result
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (n_open != 0) @(posedge clk);
  endtask

  task automatic stall_receiver(input int cycles);
    rx_hold <= 1'b1;
    repeat (cycles) @(posedge clk);
    rx_hold <= 1'b0;
  endtask

  // Main sequence
  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tuser  <= 1'b0;
    s_tdata  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: sender idles 30%, receiver 67%
    tx_idle_pct = 30;
    rx_idle_pct = 67;
    send_key(KEY_NONE);
    send_key(KEY_DOWN);   // date 0 is below range: drops to 255
    send_key(KEY_UP);     // 255 rolls over to 0
    send_key(KEY_UP);
    send_load(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, KEY_EXIT);
    send_load(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, KEY_NEXT);
    send_load(8'h59, 8'h59, 8'h23, 8'h07, 8'h31, 8'h12, 8'h99, KEY_NONE);
    send_key(KEY_UP);     // date 31 -> 1
    send_key(KEY_DOWN);   // date 1 -> 31
    send_key(KEY_NEXT);
    send_key(KEY_UP);     // month 12 -> 1
    send_key(KEY_NEXT);
    send_key(KEY_DOWN);
    send_key(KEY_NEXT);
    send_key(KEY_UP);     // weekday 7 -> 1
    send_key(KEY_NEXT);
    send_key(KEY_DOWN);
    send_key(KEY_NEXT);
    send_key(KEY_UP);     // minute 59 -> 0
    send_key(KEY_NEXT);
    send_key(KEY_DOWN);
    send_key(KEY_NEXT);   // second wraps back to date
    send_key(3'd5);
    send_key(3'd7);
    send_key(KEY_EXIT);
    random_items(630);
    wait_drained();

    // sender idles 67%, receiver 30%
    tx_idle_pct = 67;
    rx_idle_pct = 30;
    random_items(630);
    wait_drained();

    // no idling; one long receiver stall while items keep coming
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    fork
      stall_receiver(150);
      random_items(40);
    join
    random_items(630);
    wait_drained();
    repeat (10) @(posedge clk);

    $display("tb_clock_set_field_editor: %0d loads and %0d key items sent, %0d results checked",
             n_loads, n_keys, n_results);
    $display("tb_clock_set_field_editor: idling on both sides, a long output stall, %0d failures",
             n_bad);
    if (n_bad == 0 && n_open == 0)
      $display("tb_clock_set_field_editor: done, clean");
    else
      $display("tb_clock_set_field_editor: done, errors");
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
hdl/csfe_pkg.sv
hdl/csfe_store.sv
hdl/csfe_step.sv
hdl/clock_set_field_editor.sv
dv/csfe_checker.sv
dv/tb_clock_set_field_editor.sv
